@@ rtl/core/ipcidr_pkg.sv @@
// ----------------------------------------------------------------------------
// ipcidr_pkg
// shared types, codes and helpers for the ipv4 cidr table match block
// ----------------------------------------------------------------------------
package ipcidr_pkg;

  // table size default
  localparam int MAX_NETWORKS_DEF = 16;

  // field widths
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 5;
  localparam int ACC_W    = 9;
  localparam int PLEN_W   = 6;

  // request and response kinds
  localparam logic REQ_CHAR    = 1'b0;
  localparam logic REQ_LOOKUP  = 1'b1;
  localparam logic RESP_ADD    = 1'b0;
  localparam logic RESP_LOOKUP = 1'b1;

  // add status codes
  localparam logic [STATUS_W-1:0] ST_OK              = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PREFIX_TEXT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PREFIX_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL      = 3'd4;

  // characters
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // number limits
  localparam logic [ACC_W-1:0] ACC_SAT    = 9'd256;
  localparam logic [ACC_W-1:0] PREFIX_MAX = 9'd32;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  spec_char;
    logic        spec_last;
    logic [31:0] lookup_addr;
  } in_beat_t;

  typedef struct packed {
    logic                resp_kind;
    logic [STATUS_W-1:0] add_status;
    logic                hit;
    logic [ENTRY_W-1:0]  entry_total;
  } out_beat_t;

  // outcome of a finished spec, before the table-full check
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         base;
    logic [PLEN_W-1:0]   prefix;
  } parse_fin_t;

  // network mask for a prefix length of 0..32
  function automatic logic [31:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    prefix_mask = ~(32'hFFFF_FFFF >> plen);
  endfunction

endpackage

@@ rtl/core/ipcidr_parser.sv @@
// ----------------------------------------------------------------------------
// ipcidr_parser
// character-at-a-time parser for a.b.c.d[/n] network specs
// ----------------------------------------------------------------------------
module ipcidr_parser import ipcidr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] ch,
  input  logic       clear,
  output parse_fin_t fin
);

  logic                in_prefix_r, in_prefix_nxt;
  logic [1:0]          octet_pos_r, octet_pos_nxt;
  logic [ACC_W-1:0]    digit_acc_r, digit_acc_nxt;
  logic                saw_digit_r, saw_digit_nxt;
  logic [31:0]         addr_acc_r, addr_acc_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;

  logic                is_digit;
  logic [7:0]          ch_off;
  logic [11:0]         acc_mul;
  logic                close_ok;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign ch_off   = ch - CH_ZERO;
  // acc * 10 + digit, saturated at 256 below
  assign acc_mul  = (12'(digit_acc_r) << 3) + (12'(digit_acc_r) << 1) + 12'(ch_off[3:0]);
  assign close_ok = saw_digit_r && !digit_acc_r[ACC_W-1];

  always_comb begin
    in_prefix_nxt = in_prefix_r;
    octet_pos_nxt = octet_pos_r;
    digit_acc_nxt = digit_acc_r;
    saw_digit_nxt = saw_digit_r;
    addr_acc_nxt  = addr_acc_r;
    err_nxt       = err_r;
    if (clear) begin
      in_prefix_nxt = 1'b0;
      octet_pos_nxt = '0;
      digit_acc_nxt = '0;
      saw_digit_nxt = 1'b0;
      addr_acc_nxt  = '0;
      err_nxt       = ST_OK;
    end else if (take && (err_r == ST_OK)) begin
      if (is_digit) begin
        digit_acc_nxt = (acc_mul > 12'(ACC_SAT)) ? ACC_SAT : acc_mul[ACC_W-1:0];
        saw_digit_nxt = 1'b1;
      end else if (in_prefix_r) begin
        err_nxt = ST_BAD_PREFIX_TEXT;
      end else if (ch == CH_DOT) begin
        if ((octet_pos_r == 2'd3) || !close_ok) begin
          err_nxt = ST_BAD_ADDR;
        end else begin
          addr_acc_nxt  = {addr_acc_r[23:0], digit_acc_r[7:0]};
          digit_acc_nxt = '0;
          saw_digit_nxt = 1'b0;
          octet_pos_nxt = octet_pos_r + 2'd1;
        end
      end else if (ch == CH_SLASH) begin
        if ((octet_pos_r != 2'd3) || !close_ok) begin
          err_nxt = ST_BAD_ADDR;
        end else begin
          addr_acc_nxt  = {addr_acc_r[23:0], digit_acc_r[7:0]};
          digit_acc_nxt = '0;
          saw_digit_nxt = 1'b0;
          in_prefix_nxt = 1'b1;
        end
      end else begin
        err_nxt = ST_BAD_ADDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_prefix_r <= 1'b0;
      octet_pos_r <= '0;
      digit_acc_r <= '0;
      saw_digit_r <= 1'b0;
      addr_acc_r  <= '0;
      err_r       <= ST_OK;
    end else begin
      in_prefix_r <= in_prefix_nxt;
      octet_pos_r <= octet_pos_nxt;
      digit_acc_r <= digit_acc_nxt;
      saw_digit_r <= saw_digit_nxt;
      addr_acc_r  <= addr_acc_nxt;
      err_r       <= err_nxt;
    end
  end

  // end-of-spec evaluation from the held parser state
  logic [31:0]       fin_addr;
  logic [PLEN_W-1:0] fin_plen;

  always_comb begin
    fin_addr   = addr_acc_r;
    fin_plen   = PLEN_W'(PREFIX_MAX);
    fin.status = ST_OK;
    if (err_r != ST_OK) begin
      fin.status = err_r;
    end else if (!in_prefix_r) begin
      if ((octet_pos_r != 2'd3) || !close_ok) begin
        fin.status = ST_BAD_ADDR;
      end else begin
        fin_addr = {addr_acc_r[23:0], digit_acc_r[7:0]};
      end
    end else if (!saw_digit_r) begin
      fin.status = ST_BAD_PREFIX_TEXT;
    end else if (digit_acc_r > PREFIX_MAX) begin
      fin.status = ST_PREFIX_RANGE;
    end else begin
      fin_plen = digit_acc_r[PLEN_W-1:0];
    end
    fin.base   = fin_addr & prefix_mask(fin_plen);
    fin.prefix = fin_plen;
  end

endmodule

@@ rtl/core/ipv4_cidr_table_match.sv @@
// ----------------------------------------------------------------------------
// ipv4_cidr_table_match
// ipv4 network allowlist: learns cidr specs from text, answers address lookups
// ----------------------------------------------------------------------------
// usage
//   input beats carry either one spec character (req_type 0) or a lookup
//   address (req_type 1). a spec such as 10.0.0.0/8 is sent one character per
//   beat with spec_last on its final character; that beat yields one add
//   result with a status and the new entry total. a lookup beat yields one
//   result with hit set if the address lies in any stored network.
//   a spec character without last mark is absorbed without leaving S_IDLE, and
//   back-to-back characters are taken every cycle. a last character moves
//   through S_FIN and S_EMIT before its result goes to out_valid. a lookup
//   walks the table through one shared mask-and-compare unit, with a table
//   read, then a compare, per entry, stopping at the first hit; an empty
//   table goes straight to S_EMIT with a miss.
//   in_stall is high from the acceptance of a beat that yields a result
//   until that result is handed to the output register.
//   reset (rst_n low, synchronous) empties the table and the parser; table
//   contents are not cleared, only the entry count. a stalled output holds
//   its beat, and the block takes no new input while a second result waits.
// ----------------------------------------------------------------------------
module ipv4_cidr_table_match import ipcidr_pkg::*; #(
  parameter int MAX_NETWORKS = MAX_NETWORKS_DEF  // 1..31
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int CNT_W = $clog2(MAX_NETWORKS + 1);
  localparam int IDX_W = (MAX_NETWORKS > 1) ? $clog2(MAX_NETWORKS) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // taking beats
  localparam logic [2:0] S_FIN  = 3'd1;  // close a spec, store it
  localparam logic [2:0] S_READ = 3'd2;  // read one table entry
  localparam logic [2:0] S_CMP  = 3'd3;  // compare it against the address
  localparam logic [2:0] S_EMIT = 3'd4;  // hand the result to the output

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [31:0]         addr_r;
  logic                res_kind_r, res_kind_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_hit_r, res_hit_nxt;
  logic                out_valid_r;
  out_beat_t           out_data_r;

  // table storage, one write and one registered read port
  logic [31:0]         base_mem [MAX_NETWORKS];
  logic [PLEN_W-1:0]   plen_mem [MAX_NETWORKS];
  logic [31:0]         rd_base_r;
  logic [PLEN_W-1:0]   rd_plen_r;

  logic                in_take;
  logic                out_free;
  logic                tbl_full;
  logic                store_en;
  logic                entry_match;
  logic                scan_last;
  parse_fin_t          fin;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign tbl_full  = (count_r == CNT_W'(MAX_NETWORKS));
  assign store_en  = (state_r == S_FIN) && (fin.status == ST_OK) && !tbl_full;

  // the shared compare unit
  assign entry_match = ((addr_r & prefix_mask(rd_plen_r)) == rd_base_r);
  assign scan_last   = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);

  ipcidr_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_take && (in_data.req_type == REQ_CHAR)),
    .ch    (in_data.spec_char),
    .clear (state_r == S_FIN),
    .fin   (fin)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    res_kind_nxt   = res_kind_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_data.req_type == REQ_LOOKUP) begin
            res_kind_nxt   = RESP_LOOKUP;
            res_status_nxt = ST_OK;
            res_hit_nxt    = 1'b0;
            scan_idx_nxt   = '0;
            // empty table misses at once
            state_nxt      = (count_r == '0) ? S_EMIT : S_READ;
          end else if (in_data.spec_last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        res_kind_nxt = RESP_ADD;
        res_hit_nxt  = 1'b0;
        if (fin.status != ST_OK) begin
          res_status_nxt = fin.status;
        end else if (tbl_full) begin
          res_status_nxt = ST_TABLE_FULL;
        end else begin
          res_status_nxt = ST_OK;
          count_nxt      = count_r + CNT_W'(1);
        end
        state_nxt = S_EMIT;
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (entry_match) begin
          res_hit_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end else if (scan_last) begin
          state_nxt = S_EMIT;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
          state_nxt    = S_READ;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // result payload and lookup address carry no reset
  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    res_kind_r   <= res_kind_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    if (in_take && (in_data.req_type == REQ_LOOKUP)) begin
      addr_r <= in_data.lookup_addr;
    end
  end

  // table write on a good spec, registered read during the walk
  always_ff @(posedge clk) begin
    if (store_en) begin
      base_mem[count_r[IDX_W-1:0]] <= fin.base;
      plen_mem[count_r[IDX_W-1:0]] <= fin.prefix;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_base_r <= base_mem[scan_idx_r];
      rd_plen_r <= plen_mem[scan_idx_r];
    end
  end

  // output register: loads in S_EMIT once the previous beat is gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && out_free) begin
      out_data_r.resp_kind   <= res_kind_r;
      out_data_r.add_status  <= res_status_r;
      out_data_r.hit         <= res_hit_r;
      out_data_r.entry_total <= ENTRY_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the entry count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_NETWORKS))
    else $error("entry count beyond table size");

  // the count moves only by one, and only when a spec closes
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      (($past(state_r) == S_FIN) && (count_r == $past(count_r) + CNT_W'(1))))
    else $error("entry count changed outside spec close");

  // the walk reads only stored entries
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (CNT_W'(scan_idx_r) < count_r))
    else $error("table walk past last entry");

  // an add result never reports a hit, a lookup result never a status
  a_out_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.resp_kind == RESP_ADD) ? !out_data_r.hit
                                                        : (out_data_r.add_status == ST_OK)))
    else $error("result fields inconsistent with result kind");

endmodule
